@@ hdl/obb_pkg.sv @@
package obb_pkg;

  localparam int FIELD_W = 48;
  localparam int AXIS_FRAC = 14;
  localparam int CUTOFF_W = 15;
  localparam logic [CUTOFF_W-1:0] CUTOFF_RESET = 15'd16383;
  localparam int AXIS_CODE_W = 4;
  localparam int NUM_AXES = 15;
  localparam logic [AXIS_CODE_W-1:0] NO_AXIS = 4'd15;
  localparam int NUM_WORDS = 10;

  // word slots of the input beat
  localparam int W_A_CENTER = 0;
  localparam int W_A_HALF   = 1;
  localparam int W_A_AXIS   = 2;
  localparam int W_B_CENTER = 5;
  localparam int W_B_HALF   = 6;
  localparam int W_B_AXIS   = 7;

  typedef logic [FIELD_W-1:0] field_t;

endpackage

@@ hdl/obb_dot3.sv @@
module obb_dot3 #(
  parameter int AW = 17,
  parameter int BW = 16
) (
  input  logic                     clk,
  input  logic                     en,
  input  logic signed [AW-1:0]     a [3],
  input  logic signed [BW-1:0]     b [3],
  output logic signed [AW+BW-13:0] dot
);

  localparam int PW = AW + BW;
  localparam int SW = PW + 2;
  localparam logic signed [SW-1:0] HALF = SW'(1) << (obb_pkg::AXIS_FRAC - 1);

  logic signed [PW-1:0] prod [3];
  logic signed [SW-1:0] sum;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        prod[k] <= a[k] * b[k];
      end
      dot <= sum[SW-1:obb_pkg::AXIS_FRAC];
    end
  end

  // round half up: floor of (sum + half) / 2^14
  always_comb begin
    sum = SW'(prod[0]) + SW'(prod[1]) + SW'(prod[2]) + HALF;
  end

endmodule

@@ hdl/oriented_box_overlap_test.sv @@
// Oriented box overlap test by separating axes, fifteen candidate axes.
// Input channel (in_valid/in_ready): one beat carries both boxes: centres,
// half extents and three local axes each, PART_WIDTH-bit parts, x lowest.
// Output channel (out_valid/out_ready): one beat per input beat, in order:
// overlap and the first separating axis (15 when none).
// Config channel (cfg_valid/cfg_ready/cfg_data): parallel cutoff, Q1.14.
// Always ready; write it only while no beat is in flight.
// Throughput: one beat per cycle unless the receiver stalls, set by a
// six-register pipeline (part extract and centre difference, products,
// dot sums with rounding, radius and edge products, comparisons, priority
// encode) that all advances together.
// When the receiver stalls the whole pipeline holds and in_ready falls
// while the output register is full and not taken; nothing is dropped.
// Reset clears every valid bit and sets the cutoff to 16383.
module oriented_box_overlap_test #(
  parameter int PART_WIDTH = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  obb_pkg::field_t               a_center,
  input  obb_pkg::field_t               a_half_size,
  input  obb_pkg::field_t               a_axis_x,
  input  obb_pkg::field_t               a_axis_y,
  input  obb_pkg::field_t               a_axis_z,
  input  obb_pkg::field_t               b_center,
  input  obb_pkg::field_t               b_half_size,
  input  obb_pkg::field_t               b_axis_x,
  input  obb_pkg::field_t               b_axis_y,
  input  obb_pkg::field_t               b_axis_z,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          overlap,
  output logic [obb_pkg::AXIS_CODE_W-1:0] separating_axis,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [obb_pkg::CUTOFF_W-1:0]  cfg_data
);

  localparam int P    = PART_WIDTH;
  localparam int DW   = P + 1;
  localparam int CW   = 2 * P - 12;
  localparam int DAW  = 2 * P - 11;
  localparam int HW   = P + CW;
  localparam int QW   = DAW + CW;
  localparam int EW   = 4 * P - 22;
  localparam int FW   = 3 * P + 4;
  localparam int CMPW = (CW > obb_pkg::CUTOFF_W) ? CW : obb_pkg::CUTOFF_W;
  localparam int FR   = obb_pkg::AXIS_FRAC;
  localparam int NSTG = 6;

  logic [obb_pkg::CUTOFF_W-1:0] parallel_cutoff;
  logic [NSTG-1:0] vld;
  logic adv;

  assign adv       = ~vld[NSTG-1] | out_ready;
  assign in_ready  = adv;
  assign out_valid = vld[NSTG-1];
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      parallel_cutoff <= obb_pkg::CUTOFF_RESET;
    end else if (cfg_valid) begin
      parallel_cutoff <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[NSTG-2:0], in_valid};
    end
  end

  // part extraction
  obb_pkg::field_t word [obb_pkg::NUM_WORDS];
  logic [P-1:0]    part [obb_pkg::NUM_WORDS][3];

  assign word[0] = a_center;
  assign word[1] = a_half_size;
  assign word[2] = a_axis_x;
  assign word[3] = a_axis_y;
  assign word[4] = a_axis_z;
  assign word[5] = b_center;
  assign word[6] = b_half_size;
  assign word[7] = b_axis_x;
  assign word[8] = b_axis_y;
  assign word[9] = b_axis_z;

  for (genvar w = 0; w < obb_pkg::NUM_WORDS; w++) begin : g_word
    for (genvar k = 0; k < 3; k++) begin : g_part
      for (genvar n = 0; n < P; n++) begin : g_bit
        if (k * P + n < obb_pkg::FIELD_W) begin : g_in
          assign part[w][k][n] = word[w][k * P + n];
        end else begin : g_out
          assign part[w][k][n] = 1'b0;
        end
      end
    end
  end

  // stage 1: registered parts and centre difference
  logic signed [DW-1:0] d1 [3];
  logic signed [P-1:0]  ax1 [3][3];
  logic signed [P-1:0]  bx1 [3][3];
  logic [P-1:0]         ha1 [3];
  logic [P-1:0]         hb1 [3];

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k < 3; k++) begin
        d1[k]  <= DW'(signed'(part[obb_pkg::W_A_CENTER][k]))
                - DW'(signed'(part[obb_pkg::W_B_CENTER][k]));
        ha1[k] <= part[obb_pkg::W_A_HALF][k];
        hb1[k] <= part[obb_pkg::W_B_HALF][k];
        for (int i = 0; i < 3; i++) begin
          ax1[i][k] <= signed'(part[obb_pkg::W_A_AXIS + i][k]);
          bx1[i][k] <= signed'(part[obb_pkg::W_B_AXIS + i][k]);
        end
      end
    end
  end

  // stages 2-3: dot products with rounding
  logic signed [CW-1:0]  c3 [3][3];
  logic signed [DAW-1:0] da3 [3];
  logic signed [DAW-1:0] eb3 [3];
  logic [P-1:0] ha2 [3];
  logic [P-1:0] hb2 [3];
  logic [P-1:0] ha3 [3];
  logic [P-1:0] hb3 [3];

  for (genvar i = 0; i < 3; i++) begin : g_dot
    for (genvar j = 0; j < 3; j++) begin : g_cos
      obb_dot3 #(.AW(P), .BW(P)) u_cos (
        .clk (clk),
        .en  (adv),
        .a   (ax1[i]),
        .b   (bx1[j]),
        .dot (c3[i][j])
      );
    end
    obb_dot3 #(.AW(DW), .BW(P)) u_da (
      .clk (clk),
      .en  (adv),
      .a   (d1),
      .b   (ax1[i]),
      .dot (da3[i])
    );
    obb_dot3 #(.AW(DW), .BW(P)) u_eb (
      .clk (clk),
      .en  (adv),
      .a   (d1),
      .b   (bx1[i]),
      .dot (eb3[i])
    );
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      ha2 <= ha1;
      hb2 <= hb1;
      ha3 <= ha2;
      hb3 <= hb2;
    end
  end

  logic [CW-1:0] ac3 [3][3];
  logic          pair3;

  always_comb begin
    pair3 = 1'b0;
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        ac3[i][j] = c3[i][j][CW-1] ? CW'(-c3[i][j]) : CW'(c3[i][j]);
        if (CMPW'(ac3[i][j]) > CMPW'(parallel_cutoff)) begin
          pair3 = 1'b1;
        end
      end
    end
  end

  // stage 4: radius and edge products
  logic [HW-1:0]         pha4 [3][3][3];
  logic [HW-1:0]         phb4 [3][3][3];
  logic signed [QW-1:0]  q1_4 [3][3];
  logic signed [QW-1:0]  q2_4 [3][3];
  logic [DAW-1:0]        daa4 [3];
  logic [DAW-1:0]        eba4 [3];
  logic [P-1:0]          ha4 [3];
  logic [P-1:0]          hb4 [3];
  logic                  pair4;

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        daa4[i] <= da3[i][DAW-1] ? DAW'(-da3[i]) : DAW'(da3[i]);
        eba4[i] <= eb3[i][DAW-1] ? DAW'(-eb3[i]) : DAW'(eb3[i]);
        for (int a = 0; a < 3; a++) begin
          for (int b = 0; b < 3; b++) begin
            pha4[a][b][i] <= HW'(ha3[a]) * HW'(ac3[b][i]);
            phb4[i][a][b] <= HW'(hb3[a]) * HW'(ac3[i][b]);
          end
        end
        for (int j = 0; j < 3; j++) begin
          q1_4[i][j] <= QW'(da3[(i + 2) % 3]) * QW'(c3[(i + 1) % 3][j]);
          q2_4[i][j] <= QW'(da3[(i + 1) % 3]) * QW'(c3[(i + 2) % 3][j]);
        end
      end
      ha4   <= ha3;
      hb4   <= hb3;
      pair4 <= pair3;
    end
  end

  // stage 5: comparisons
  logic [obb_pkg::NUM_AXES-1:0] sep4;
  logic [obb_pkg::NUM_AXES-1:0] sep5;

  always_comb begin
    logic [FW-1:0] lhs;
    logic [FW-1:0] rhs;
    logic signed [EW-1:0] diff;
    logic [EW-1:0] span;
    logic [EW-1:0] rad;
    int i1, i2, j1, j2;
    for (int i = 0; i < 3; i++) begin
      lhs = FW'({daa4[i], {FR{1'b0}}});
      rhs = FW'({ha4[i], {FR{1'b0}}}) + FW'(phb4[i][0][0]) + FW'(phb4[i][1][1])
          + FW'(phb4[i][2][2]);
      sep4[i] = lhs > rhs;
    end
    for (int j = 0; j < 3; j++) begin
      lhs = FW'({eba4[j], {FR{1'b0}}});
      rhs = FW'({hb4[j], {FR{1'b0}}}) + FW'(pha4[0][0][j]) + FW'(pha4[1][1][j])
          + FW'(pha4[2][2][j]);
      sep4[3 + j] = lhs > rhs;
    end
    for (int i = 0; i < 3; i++) begin
      i1 = (i + 1) % 3;
      i2 = (i + 2) % 3;
      for (int j = 0; j < 3; j++) begin
        j1 = (j + 1) % 3;
        j2 = (j + 2) % 3;
        diff = EW'(q1_4[i][j]) - EW'(q2_4[i][j]);
        span = diff[EW-1] ? EW'(-diff) : EW'(diff);
        rad  = EW'(pha4[i1][i2][j]) + EW'(pha4[i2][i1][j])
             + EW'(phb4[i][j1][j2]) + EW'(phb4[i][j2][j1]);
        sep4[6 + 3 * i + j] = ~pair4 & (span > rad);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sep5 <= sep4;
    end
  end

  // stage 6: first separating axis
  logic [obb_pkg::AXIS_CODE_W-1:0] axis5;

  always_comb begin
    axis5 = obb_pkg::NO_AXIS;
    for (int n = obb_pkg::NUM_AXES - 1; n >= 0; n--) begin
      if (sep5[n]) begin
        axis5 = obb_pkg::AXIS_CODE_W'(n);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      separating_axis <= axis5;
      overlap         <= (axis5 == obb_pkg::NO_AXIS);
    end
  end

  a_overlap_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (overlap == (separating_axis == obb_pkg::NO_AXIS)))
    else $error("overlap flag disagrees with axis code");

  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> !out_valid)
    else $error("output valid right after reset");

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    !adv |=> $stable(vld))
    else $error("pipeline valid bits moved during stall");

  a_cfg_idle: assert property (@(posedge clk) disable iff (rst)
    cfg_valid |-> (vld == '0))
    else $error("config written with beats in flight");

endmodule

@@ tb/oriented_box_overlap_test_tb.sv @@
module oriented_box_overlap_test_tb;

  localparam int PW = 16;

  typedef struct {
    obb_pkg::field_t w [obb_pkg::NUM_WORDS];
  } box_pair_t;

  typedef struct {
    logic                            overlap;
    logic [obb_pkg::AXIS_CODE_W-1:0] axis;
  } verdict_t;

  class overlap_scoreboard;
    logic [obb_pkg::CUTOFF_W-1:0] cutoff;
    verdict_t pending[$];
    int errors;

    function new();
      cutoff = obb_pkg::CUTOFF_RESET;
      errors = 0;
    endfunction

    function longint part_s(obb_pkg::field_t w, int k);
      logic [PW-1:0] p;
      p = w[k*PW +: PW];
      return longint'($signed(p));
    endfunction

    function longint part_u(obb_pkg::field_t w, int k);
      return longint'({48'd0, w[k*PW +: PW]});
    endfunction

    function longint rnd(longint v);
      return (v + (64'sd1 <<< (obb_pkg::AXIS_FRAC - 1))) >>> obb_pkg::AXIS_FRAC;
    endfunction

    function longint mag(longint v);
      return v < 0 ? -v : v;
    endfunction

    function logic [obb_pkg::AXIS_CODE_W-1:0] first_gap(box_pair_t bp);
      longint d[3], ha[3], hb[3], ax[3][3], bx[3][3];
      longint c[3][3], ac[3][3], da[3], eb[3];
      longint ra, rb, span;
      bit par;
      int i1, i2, j1, j2;
      par = 0;
      for (int k = 0; k < 3; k++) begin
        d[k] = part_s(bp.w[obb_pkg::W_A_CENTER], k) - part_s(bp.w[obb_pkg::W_B_CENTER], k);
        ha[k] = part_u(bp.w[obb_pkg::W_A_HALF], k);
        hb[k] = part_u(bp.w[obb_pkg::W_B_HALF], k);
        for (int i = 0; i < 3; i++) begin
          ax[i][k] = part_s(bp.w[obb_pkg::W_A_AXIS+i], k);
          bx[i][k] = part_s(bp.w[obb_pkg::W_B_AXIS+i], k);
        end
      end
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          c[i][j] = rnd(ax[i][0]*bx[j][0] + ax[i][1]*bx[j][1] + ax[i][2]*bx[j][2]);
          ac[i][j] = mag(c[i][j]);
          if (ac[i][j] > longint'(cutoff)) par = 1;
        end
        da[i] = rnd(d[0]*ax[i][0] + d[1]*ax[i][1] + d[2]*ax[i][2]);
        eb[i] = rnd(d[0]*bx[i][0] + d[1]*bx[i][1] + d[2]*bx[i][2]);
      end
      for (int i = 0; i < 3; i++) begin
        ra = ha[i] <<< obb_pkg::AXIS_FRAC;
        rb = hb[0]*ac[i][0] + hb[1]*ac[i][1] + hb[2]*ac[i][2];
        if ((mag(da[i]) <<< obb_pkg::AXIS_FRAC) > ra + rb) return 4'(i);
      end
      for (int j = 0; j < 3; j++) begin
        ra = ha[0]*ac[0][j] + ha[1]*ac[1][j] + ha[2]*ac[2][j];
        rb = hb[j] <<< obb_pkg::AXIS_FRAC;
        if ((mag(eb[j]) <<< obb_pkg::AXIS_FRAC) > ra + rb) return 4'(3 + j);
      end
      if (par) return obb_pkg::NO_AXIS;
      for (int i = 0; i < 3; i++) begin
        i1 = (i + 1) % 3;
        i2 = (i + 2) % 3;
        for (int j = 0; j < 3; j++) begin
          j1 = (j + 1) % 3;
          j2 = (j + 2) % 3;
          span = mag(da[i2]*c[i1][j] - da[i1]*c[i2][j]);
          ra = ha[i1]*ac[i2][j] + ha[i2]*ac[i1][j];
          rb = hb[j1]*ac[i][j2] + hb[j2]*ac[i][j1];
          if (span > ra + rb) return 4'(6 + 3*i + j);
        end
      end
      return obb_pkg::NO_AXIS;
    endfunction

    function void note_pair(box_pair_t bp);
      verdict_t v;
      v.axis = first_gap(bp);
      v.overlap = (v.axis == obb_pkg::NO_AXIS);
      pending.push_back(v);
    endfunction

    function void check_verdict(logic ov, logic [obb_pkg::AXIS_CODE_W-1:0] ax);
      verdict_t v;
      if (pending.size() == 0) begin
        $display("%0t: unexpected beat overlap=%0d axis=%0d", $time, ov, ax);
        errors++;
        return;
      end
      v = pending.pop_front();
      if (ov !== v.overlap) begin
        $display("%0t: overlap expected %0d actual %0d", $time, v.overlap, ov);
        errors++;
      end
      if (ax !== v.axis) begin
        $display("%0t: separating_axis expected %0d actual %0d", $time, v.axis, ax);
        errors++;
      end
    endfunction
  endclass

  logic clk, rst;
  logic in_valid, in_ready, out_valid, out_ready, overlap;
  logic [obb_pkg::AXIS_CODE_W-1:0] separating_axis;
  logic cfg_valid, cfg_ready;
  logic [obb_pkg::CUTOFF_W-1:0] cfg_data;
  obb_pkg::field_t words [obb_pkg::NUM_WORDS];
  overlap_scoreboard sb;

  oriented_box_overlap_test #(.PART_WIDTH(PW)) i_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .a_center(words[obb_pkg::W_A_CENTER]), .a_half_size(words[obb_pkg::W_A_HALF]),
    .a_axis_x(words[obb_pkg::W_A_AXIS]), .a_axis_y(words[obb_pkg::W_A_AXIS+1]),
    .a_axis_z(words[obb_pkg::W_A_AXIS+2]),
    .b_center(words[obb_pkg::W_B_CENTER]), .b_half_size(words[obb_pkg::W_B_HALF]),
    .b_axis_x(words[obb_pkg::W_B_AXIS]), .b_axis_y(words[obb_pkg::W_B_AXIS+1]),
    .b_axis_z(words[obb_pkg::W_B_AXIS+2]),
    .out_valid(out_valid), .out_ready(out_ready),
    .overlap(overlap), .separating_axis(separating_axis),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  initial begin
    #20000000;
    $display("Some tests failed");
    $finish;
  end

  // output side: random stalls, check on accept
  initial begin
    int gap;
    out_ready = 0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 8);
      out_ready = 0;
      repeat (gap) @(negedge clk);
      out_ready = 1;
      do @(posedge clk); while (!out_valid);
      sb.check_verdict(overlap, separating_axis);
      @(negedge clk);
    end
  end

  task automatic send_pair(box_pair_t bp, int gap);
    repeat (gap) @(negedge clk);
    words = bp.w;
    in_valid = 1;
    do @(posedge clk); while (!in_ready);
    sb.note_pair(bp);
    @(negedge clk);
    in_valid = 0;
  endtask

  task automatic write_cutoff(logic [obb_pkg::CUTOFF_W-1:0] v);
    while (sb.pending.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
    cfg_data <= v;
    cfg_valid <= 1;
    do @(posedge clk); while (!cfg_ready);
    sb.cutoff = v;
    @(negedge clk);
    cfg_valid <= 0;
  endtask

  function automatic obb_pkg::field_t pack3(logic [15:0] x, logic [15:0] y, logic [15:0] z);
    return {z, y, x};
  endfunction

  function automatic logic [15:0] jitter(int q);
    return 16'($signed(q) + $signed($urandom_range(0, 400)) - 200);
  endfunction

  // well-formed-ish box pair: near-unit axes, modest centres and extents
  function automatic box_pair_t shaped_pair(bit aligned);
    box_pair_t bp;
    int perm;
    logic [15:0] one;
    for (int b = 0; b < 2; b++) begin
      int base;
      base = b ? obb_pkg::W_B_CENTER : obb_pkg::W_A_CENTER;
      bp.w[base] = pack3(16'($urandom_range(0, 2000) - 1000),
                         16'($urandom_range(0, 2000) - 1000),
                         16'($urandom_range(0, 2000) - 1000));
      bp.w[base+1] = pack3(16'($urandom_range(0, 800)), 16'($urandom_range(0, 800)),
                           16'($urandom_range(0, 800)));
      perm = $urandom_range(0, 2);
      for (int i = 0; i < 3; i++) begin
        logic [15:0] p [3];
        one = $urandom_range(0, 1) ? 16'd16384 : -16'sd16384;
        for (int k = 0; k < 3; k++)
          p[k] = (k == (i + perm) % 3) ? (aligned ? one : jitter($signed(one) - 1500))
                                       : (aligned ? 16'd0 : jitter(0) * 4);
        bp.w[base+2+i] = pack3(p[0], p[1], p[2]);
      end
    end
    return bp;
  endfunction

  function automatic box_pair_t noise_pair();
    box_pair_t bp;
    for (int i = 0; i < obb_pkg::NUM_WORDS; i++)
      bp.w[i] = 48'({$urandom(), $urandom()});
    return bp;
  endfunction

  initial begin
    box_pair_t bp;
    logic [obb_pkg::CUTOFF_W-1:0] cutoffs [5];
    sb = new();
    rst = 1;
    in_valid = 0;
    cfg_valid = 0;
    cfg_data = '0;
    for (int i = 0; i < obb_pkg::NUM_WORDS; i++) words[i] = '0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst = 0;

    // directed: zeros, all ones, extremes, concentric and far apart boxes
    for (int i = 0; i < obb_pkg::NUM_WORDS; i++) bp.w[i] = '0;
    send_pair(bp, 0);
    for (int i = 0; i < obb_pkg::NUM_WORDS; i++) bp.w[i] = '1;
    send_pair(bp, 1);
    for (int i = 0; i < obb_pkg::NUM_WORDS; i++) bp.w[i] = 48'h8000_8000_8000;
    send_pair(bp, 0);
    for (int i = 0; i < obb_pkg::NUM_WORDS; i++) bp.w[i] = 48'h7FFF_7FFF_7FFF;
    send_pair(bp, 2);
    for (int n = 0; n < 6; n++) begin
      bp = shaped_pair(1);
      bp.w[obb_pkg::W_B_CENTER] = bp.w[obb_pkg::W_A_CENTER];
      send_pair(bp, 0);
      bp = shaped_pair(1);
      bp.w[obb_pkg::W_A_CENTER] = pack3(16'h7FFF, 16'h7FFF, 16'h7FFF);
      bp.w[obb_pkg::W_B_CENTER] = pack3(16'h8000, 16'h8000, 16'h8000);
      send_pair(bp, 0);
    end
    for (int n = 0; n < 8; n++) send_pair(shaped_pair(0), 0);

    cutoffs = '{15'd0, 15'h7FFF, 15'd16384, 15'd12000, obb_pkg::CUTOFF_RESET};
    for (int ph = 0; ph < 5; ph++) begin
      write_cutoff(cutoffs[ph]);
      for (int n = 0; n < 215; n++) begin
        int r;
        r = $urandom_range(0, 9);
        if (r < 6) bp = shaped_pair(0);
        else if (r < 8) bp = shaped_pair(1);
        else bp = noise_pair();
        send_pair(bp, ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 8));
      end
    end

    while (sb.pending.size() != 0) @(negedge clk);
    repeat (20) @(negedge clk);
    if (sb.errors == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

endmodule
